// File: rtl/ccg_pkg.sv
// Package for the concave coverage gain engine: sizes, constants, word types.
package ccg_pkg;
  localparam int FEAT_COUNT = 65536;
  localparam int ADDR_W     = $clog2(FEAT_COUNT);
  localparam int LOG_FRAC   = 16;
  localparam int FB         = LOG_FRAC + 4;
  localparam int FB_CNT_W   = $clog2(FB);
  localparam logic [31:0] LN2_Q28  = 32'd186065280;
  localparam logic [31:0] GAIN_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] OBJ_MAX  = 48'hFFFF_FFFF_FFFF;

  // input word as latched at accept
  typedef struct packed {
    logic        action;
    logic [19:0] candidate_id;
    logic [15:0] feature_index;
    logic [15:0] feature_count;
    logic        last;
  } elem_t;
endpackage

// File: rtl/concave_coverage_gain_engine.sv
// Top level: marginal gain of ln(1+x) coverage over a per-feature mass table.
// After reset the mass table is cleared, one entry a cycle, all FEAT_COUNT (65536) entries.
// Each in-range element takes two logarithms, each a normalizing shift of one bit a cycle
// and FB squarings on one 32x32 multiplier; an out-of-range element skips them.
// A last element passes through S_FIN to load the output register, waiting there while it is full; not ready meanwhile.
// Reset is synchronous, active high; table, gain sum and objective restart at zero.
module concave_coverage_gain_engine (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,   // candidate_id[19:0], feature_index[35:20], feature_count[51:36]
  input  logic [0:0]   s_tuser,   // action
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // result_id[19:0], gain[51:20], objective_after[99:52]
  output logic [1:0]   m_tuser    // committed[1], gain_saturated[0]
);
  import ccg_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_MASS = 4'd3;
  localparam logic [3:0] S_LINI = 4'd4;
  localparam logic [3:0] S_NORM = 4'd5;
  localparam logic [3:0] S_SQ   = 4'd6;
  localparam logic [3:0] S_LMUL = 4'd7;
  localparam logic [3:0] S_LRND = 4'd8;
  localparam logic [3:0] S_ACC  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]          st;
  logic [ADDR_W-1:0]   clr_addr;
  elem_t               el;
  logic                in_range;
  logic [31:0]         mem [FEAT_COUNT];
  logic [31:0]         rd_data;
  logic [31:0]         mass;
  logic [33:0]         y;
  logic [5:0]          e;
  logic [FB-1:0]       l2;
  logic [FB_CNT_W-1:0] bit_cnt;
  logic                lsel;
  logic [31:0]         ln_lo, ln_hi;
  logic [63:0]         prod;
  logic [31:0]         gain_sum;
  logic                sat_seen;
  logic [47:0]         objective;

  // shared multiplier: squaring or scale by ln 2
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] sq_t;
  always_comb begin
    if (st == S_LMUL) begin
      mul_a = 32'({e, l2});
      mul_b = LN2_Q28;
    end else begin
      mul_a = y[31:0];
      mul_b = y[31:0];
    end
    mul_p = mul_a * mul_b;
    sq_t  = mul_p[63:31];
  end

  // accumulate and write-back values
  logic [31:0] d;
  logic [32:0] gsum, msum;
  logic [48:0] osum;
  logic        we;
  logic [ADDR_W-1:0] wa;
  logic [31:0] wd;
  always_comb begin
    d    = (ln_hi > ln_lo) ? ln_hi - ln_lo : 32'd0;
    gsum = {1'b0, gain_sum} + {1'b0, d};
    msum = {1'b0, mass} + 33'(el.feature_count);
    osum = {1'b0, objective} + 49'(gain_sum);
    we   = (st == S_CLR) || (st == S_ACC && in_range && el.action);
    wa   = (st == S_CLR) ? clr_addr : el.feature_index[ADDR_W-1:0];
    wd   = (st == S_CLR) ? 32'd0 : (msum[32] ? 32'hFFFF_FFFF : msum[31:0]);
  end

  // mass table
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[el.feature_index[ADDR_W-1:0]];
  end

  assign s_tready = (st == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLR;
      clr_addr  <= '0;
      m_tvalid  <= 1'b0;
      gain_sum  <= '0;
      sat_seen  <= 1'b0;
      objective <= '0;
    end else begin
      // output word taken; S_FIN reloads it on its own
      if (m_tvalid && m_tready && st != S_FIN) m_tvalid <= 1'b0;
      unique case (st)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) st <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            el.action        <= s_tuser[0];
            el.candidate_id  <= s_tdata[19:0];
            el.feature_index <= s_tdata[35:20];
            el.feature_count <= s_tdata[51:36];
            el.last          <= s_tlast;
            in_range         <= (32'(s_tdata[35:20]) < 32'(FEAT_COUNT));
            st               <= S_RD;
          end
        end
        S_RD: st <= in_range ? S_MASS : S_ACC;
        S_MASS: begin
          mass <= rd_data;
          lsel <= 1'b0;
          st   <= S_LINI;
        end
        S_LINI: begin
          y  <= (lsel ? 34'(mass) + 34'(el.feature_count) : 34'(mass)) + 34'd1;
          e  <= 6'd31;
          st <= S_NORM;
        end
        // one bit a cycle to [2^31, 2^32)
        S_NORM: begin
          if (y[33:32] != 2'b00) begin
            y <= y >> 1;
            e <= e + 6'd1;
          end else if (!y[31]) begin
            y <= y << 1;
            e <= e - 6'd1;
          end else begin
            l2      <= '0;
            bit_cnt <= '0;
            st      <= S_SQ;
          end
        end
        // one fraction bit of log2 per squaring
        S_SQ: begin
          if (sq_t[32]) begin
            y  <= 34'(sq_t[32:1]);
            l2 <= {l2[FB-2:0], 1'b1};
          end else begin
            y  <= 34'(sq_t);
            l2 <= {l2[FB-2:0], 1'b0};
          end
          bit_cnt <= bit_cnt + 1'b1;
          if (32'(bit_cnt) == FB - 1) st <= S_LMUL;
        end
        S_LMUL: begin
          prod <= mul_p;
          st   <= S_LRND;
        end
        S_LRND: begin
          if (lsel) begin
            ln_hi <= 32'((prod + 64'h8000_0000) >> 32);
            st    <= S_ACC;
          end else begin
            ln_lo <= 32'((prod + 64'h8000_0000) >> 32);
            lsel  <= 1'b1;
            st    <= S_LINI;
          end
        end
        S_ACC: begin
          if (in_range) begin
            if (gsum >= {1'b0, GAIN_MAX}) begin
              gain_sum <= GAIN_MAX;
              sat_seen <= 1'b1;
            end else begin
              gain_sum <= gsum[31:0];
            end
          end
          st <= el.last ? S_FIN : S_IDLE;
        end
        // load the output word once the register is free
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid       <= 1'b1;
            m_tdata[19:0]  <= el.candidate_id;
            m_tdata[51:20] <= gain_sum;
            m_tdata[99:52] <= osum[48] ? OBJ_MAX : osum[47:0];
            m_tdata[103:100] <= 4'd0;
            m_tuser        <= {el.action, sat_seen};
            if (el.action) objective <= osum[48] ? OBJ_MAX : osum[47:0];
            gain_sum <= '0;
            sat_seen <= 1'b0;
            st       <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // checks
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("ready during table clear");
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[51:20] == GAIN_MAX)
    else $error("saturation flag without maximum gain");
  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    st == S_NORM |-> y != 34'd0)
    else $error("normalizing a zero word");
endmodule
